// ----- rtl/bqlp_pkg.sv -----
// Shared types and constants for the biquad low-pass filter.
// Used by bqlp_core and biquad_lowpass_filter; no dependencies.
`timescale 1ns / 1ps

package bqlp_pkg;

    localparam int SampleW  = 16;
    localparam int CoefW    = 32;
    localparam int CoefFrac = 29;
    localparam int HistFrac = 23;
    localparam int HistW    = HistFrac + 1;
    localparam int UpShift  = HistFrac - (SampleW - 1);
    localparam int XProdW   = CoefW + SampleW + UpShift;
    localparam int YProdW   = CoefW + HistW;
    localparam int TermW    = ((XProdW > YProdW) ? XProdW : YProdW) - CoefFrac + 1;
    localparam int SumW     = TermW + 3;
    localparam int CfgAddrW = 3;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_B0     = 3'd1,
        CFG_B1     = 3'd2,
        CFG_B2     = 3'd3,
        CFG_A1     = 3'd4,
        CFG_A2     = 3'd5
    } t_cfg_addr;

    typedef struct packed {
        logic signed [CoefW-1:0] b0;
        logic signed [CoefW-1:0] b1;
        logic signed [CoefW-1:0] b2;
        logic signed [CoefW-1:0] a1;
        logic signed [CoefW-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic signed [SampleW-1:0] x1;
        logic signed [SampleW-1:0] x2;
        logic signed [HistW-1:0]   y1;
        logic signed [HistW-1:0]   y2;
    } t_hist;

    typedef struct packed {
        logic signed [HistW-1:0]   y0;
        logic signed [SampleW-1:0] sample;
        logic                      clipped;
    } t_core_out;

endpackage

// ----- rtl/bqlp_core.sv -----
// Combinational biquad arithmetic: five products, floor shifts, sum, saturation; bypass passes the input.
// Depends on bqlp_pkg.
`timescale 1ns / 1ps

module bqlp_core (
    input  bqlp_pkg::t_coefs                      i_coefs,
    input  bqlp_pkg::t_hist                       i_hist,
    input  logic signed [bqlp_pkg::SampleW-1:0]   i_x,
    input  logic                                  i_bypass,
    output bqlp_pkg::t_core_out                   o_res
);

    localparam logic signed [bqlp_pkg::SumW-1:0] HMax =
        bqlp_pkg::SumW'((64'sd1 <<< bqlp_pkg::HistFrac) - 64'sd1);
    localparam logic signed [bqlp_pkg::SumW-1:0] HMin =
        bqlp_pkg::SumW'(-(64'sd1 <<< bqlp_pkg::HistFrac));

    logic signed [bqlp_pkg::CoefW-1:0]   w_b0, w_b1, w_b2, w_a1, w_a2;
    logic signed [bqlp_pkg::SampleW-1:0] w_x1, w_x2;
    logic signed [bqlp_pkg::HistW-1:0]   w_y1, w_y2;
    logic signed [bqlp_pkg::XProdW-1:0]  w_pb0, w_pb1, w_pb2;
    logic signed [bqlp_pkg::YProdW-1:0]  w_pa1, w_pa2;
    logic signed [bqlp_pkg::TermW-1:0]   w_tb0, w_tb1, w_tb2, w_ta1, w_ta2;
    logic signed [bqlp_pkg::SumW-1:0]    w_sum;
    logic signed [bqlp_pkg::HistW-1:0]   w_ysat;
    logic signed [bqlp_pkg::HistW-1:0]   w_ypass;
    logic                                w_hi, w_lo;

    assign w_b0 = i_coefs.b0;
    assign w_b1 = i_coefs.b1;
    assign w_b2 = i_coefs.b2;
    assign w_a1 = i_coefs.a1;
    assign w_a2 = i_coefs.a2;
    assign w_x1 = i_hist.x1;
    assign w_x2 = i_hist.x2;
    assign w_y1 = i_hist.y1;
    assign w_y2 = i_hist.y2;

    assign w_pb0 = (w_b0 * i_x)  <<< bqlp_pkg::UpShift;
    assign w_pb1 = (w_b1 * w_x1) <<< bqlp_pkg::UpShift;
    assign w_pb2 = (w_b2 * w_x2) <<< bqlp_pkg::UpShift;
    assign w_pa1 = w_a1 * w_y1;
    assign w_pa2 = w_a2 * w_y2;

    assign w_tb0 = bqlp_pkg::TermW'(w_pb0 >>> bqlp_pkg::CoefFrac);
    assign w_tb1 = bqlp_pkg::TermW'(w_pb1 >>> bqlp_pkg::CoefFrac);
    assign w_tb2 = bqlp_pkg::TermW'(w_pb2 >>> bqlp_pkg::CoefFrac);
    assign w_ta1 = bqlp_pkg::TermW'(w_pa1 >>> bqlp_pkg::CoefFrac);
    assign w_ta2 = bqlp_pkg::TermW'(w_pa2 >>> bqlp_pkg::CoefFrac);

    assign w_sum = bqlp_pkg::SumW'(w_tb0) + bqlp_pkg::SumW'(w_tb1)
                 + bqlp_pkg::SumW'(w_tb2) - bqlp_pkg::SumW'(w_ta1)
                 - bqlp_pkg::SumW'(w_ta2);

    assign w_hi = (w_sum > HMax);
    assign w_lo = (w_sum < HMin);

    always_comb begin
        if (w_hi) begin
            w_ysat = bqlp_pkg::HistW'(HMax);
        end else if (w_lo) begin
            w_ysat = bqlp_pkg::HistW'(HMin);
        end else begin
            w_ysat = bqlp_pkg::HistW'(w_sum);
        end
    end

    assign w_ypass = bqlp_pkg::HistW'(i_x) <<< bqlp_pkg::UpShift;

    always_comb begin
        if (i_bypass) begin
            o_res.y0      = w_ypass;
            o_res.sample  = i_x;
            o_res.clipped = 1'b0;
        end else begin
            o_res.y0      = w_ysat;
            o_res.sample  = bqlp_pkg::SampleW'(w_ysat >>> bqlp_pkg::UpShift);
            o_res.clipped = w_hi | w_lo;
        end
    end

endmodule

// ----- rtl/biquad_lowpass_filter.sv -----
// Direct-form-I biquad low-pass filter, top level with config registers.
// Each input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the sink is ready; one input can be accepted while a result waits for the sink.
// Feedback closes through bqlp_core and the history registers.
// Reset (synchronous, active low) clears coefficients, enable, history, warm-up count.
// Depends on bqlp_pkg and bqlp_core.
`timescale 1ns / 1ps

module biquad_lowpass_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bqlp_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [bqlp_pkg::CoefW-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // [15:0] sample_in
    input  logic                              s_axis_tuser,   // [0] stream_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [15:0] sample_out
    output logic                              m_axis_tuser    // [0] clipped
);

    logic                                r_enable;
    bqlp_pkg::t_coefs                    r_coefs;
    logic                                r_in_valid;
    logic signed [bqlp_pkg::SampleW-1:0] r_x;
    logic                                r_start;
    bqlp_pkg::t_hist                     r_hist;
    logic [1:0]                          r_warm;
    logic                                r_out_valid;
    logic [bqlp_pkg::SampleW-1:0]        r_out_sample;
    logic                                r_out_clip;

    logic [1:0]                          w_warm;
    logic [1:0]                          n_warm;
    logic                                w_bypass;
    logic                                w_adv;
    logic                                w_load;
    bqlp_pkg::t_core_out                 w_res;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    // warm-up count saturates at 2; stream start restarts it before use
    assign w_warm   = r_start ? 2'd0 : r_warm;
    assign w_bypass = !r_enable || !w_warm[1];
    assign n_warm   = w_warm[1] ? w_warm : w_warm + 2'd1;

    bqlp_core u_core (
        .i_coefs  (r_coefs),
        .i_hist   (r_hist),
        .i_x      (r_x),
        .i_bypass (w_bypass),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_coefs  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bqlp_pkg::CFG_ENABLE: r_enable   <= i_cfg_data[0];
                bqlp_pkg::CFG_B0:     r_coefs.b0 <= i_cfg_data;
                bqlp_pkg::CFG_B1:     r_coefs.b1 <= i_cfg_data;
                bqlp_pkg::CFG_B2:     r_coefs.b2 <= i_cfg_data;
                bqlp_pkg::CFG_A1:     r_coefs.a1 <= i_cfg_data;
                bqlp_pkg::CFG_A2:     r_coefs.a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x     <= s_axis_tdata;
            r_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_warm <= 2'd0;
        end else if (w_adv) begin
            r_hist.x2 <= r_hist.x1;
            r_hist.x1 <= r_x;
            r_hist.y2 <= r_hist.y1;
            r_hist.y1 <= w_res.y0;
            r_warm    <= n_warm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_sample <= w_res.sample;
            r_out_clip   <= w_res.clipped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = r_out_clip;

endmodule

// ----- bench/tb_biquad_lowpass_filter.sv -----
// Self-checking testbench for biquad_lowpass_filter: stream-bus stimulus, config writes
// and an in-bench fixed-point predictor that checks every output beat.
// Depends on bqlp_pkg and the biquad_lowpass_filter RTL.
`timescale 1ns / 1ps

module tb_biquad_lowpass_filter;

    localparam int     LATENCY      = 2;
    localparam int     HOLD_CYCLES  = 64;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 94;
    localparam longint HIST_UP      = longint'(1) << bqlp_pkg::UpShift;
    localparam longint HIST_MAX     = (longint'(1) << bqlp_pkg::HistFrac) - 1;
    localparam longint HIST_MIN     = -(longint'(1) << bqlp_pkg::HistFrac);
    localparam logic [bqlp_pkg::CfgAddrW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [bqlp_pkg::CfgAddrW-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [bqlp_pkg::CoefW-1:0]    COEF_ONE     = 32'h2000_0000;
    localparam logic [bqlp_pkg::CoefW-1:0]    COEF_MAX     = 32'h7FFF_FFFF;
    localparam logic [bqlp_pkg::CoefW-1:0]    COEF_MIN     = 32'h8000_0000;

    typedef enum int {
        SET_LOWPASS, SET_WILD, SET_MILD, SET_BYPASS, SET_EDGE_HI, SET_EDGE_LO
    } t_setting;

    class biquad_sample_checker;
        typedef struct {
            logic [bqlp_pkg::SampleW-1:0] sample;
            logic                         clipped;
        } t_expect;

        t_expect expected_samples[$];
        int      errors = 0;
        logic    enable = 1'b0;
        longint  coef_b0 = 0, coef_b1 = 0, coef_b2 = 0, coef_a1 = 0, coef_a2 = 0;
        longint  x_d1 = 0, x_d2 = 0, y_d1 = 0, y_d2 = 0;
        int      warm_seen = 0;

        function void write_reg(logic [bqlp_pkg::CfgAddrW-1:0] addr,
                                logic [bqlp_pkg::CoefW-1:0] data);
            case (addr)
                bqlp_pkg::CFG_ENABLE: enable  = data[0];
                bqlp_pkg::CFG_B0:     coef_b0 = longint'($signed(data));
                bqlp_pkg::CFG_B1:     coef_b1 = longint'($signed(data));
                bqlp_pkg::CFG_B2:     coef_b2 = longint'($signed(data));
                bqlp_pkg::CFG_A1:     coef_a1 = longint'($signed(data));
                bqlp_pkg::CFG_A2:     coef_a2 = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function void predict_sample(logic [bqlp_pkg::SampleW-1:0] din, logic start);
            longint  x0;
            longint  y0;
            t_expect want;
            x0 = longint'($signed(din));
            want.clipped = 1'b0;
            if (start) warm_seen = 0;
            if (!enable || warm_seen < 2) begin
                y0 = x0 * HIST_UP;
            end else begin
                y0 = ((coef_b0 * x0 * HIST_UP) >>> bqlp_pkg::CoefFrac)
                   + ((coef_b1 * x_d1 * HIST_UP) >>> bqlp_pkg::CoefFrac)
                   + ((coef_b2 * x_d2 * HIST_UP) >>> bqlp_pkg::CoefFrac)
                   - ((coef_a1 * y_d1) >>> bqlp_pkg::CoefFrac)
                   - ((coef_a2 * y_d2) >>> bqlp_pkg::CoefFrac);
                if (y0 > HIST_MAX) begin
                    y0 = HIST_MAX;
                    want.clipped = 1'b1;
                end else if (y0 < HIST_MIN) begin
                    y0 = HIST_MIN;
                    want.clipped = 1'b1;
                end
            end
            want.sample = 16'(y0 >>> bqlp_pkg::UpShift);
            expected_samples.push_back(want);
            x_d2 = x_d1;
            x_d1 = x0;
            y_d2 = y_d1;
            y_d1 = y0;
            if (warm_seen < 2) warm_seen++;
        endfunction

        function void check_sample(logic [bqlp_pkg::SampleW-1:0] dout, logic clip);
            t_expect want;
            if (expected_samples.size() == 0) begin
                $error("output beat with nothing expected: sample_out %0d", $signed(dout));
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (dout !== want.sample) begin
                $error("sample_out: expected %0d, actual %0d",
                       $signed(want.sample), $signed(dout));
                errors++;
            end
            if (clip !== want.clipped) begin
                $error("clipped: expected %0d, actual %0d", want.clipped, clip);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_samples.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bqlp_pkg::CfgAddrW-1:0] i_cfg_addr;
    logic [bqlp_pkg::CoefW-1:0]    i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata;   // [15:0] sample_in
    logic                          s_axis_tuser;   // [0] stream_start
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [15:0]                   m_axis_tdata;   // [15:0] sample_out
    logic                          m_axis_tuser;   // [0] clipped

    biquad_sample_checker bq_check;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_req       = 1'b0;

    biquad_lowpass_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // sink side: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) bq_check.write_reg(i_cfg_addr, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) bq_check.predict_sample(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) bq_check.check_sample(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_beat(input logic [15:0] sample, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bq_check.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bqlp_pkg::CfgAddrW-1:0] addr,
                             input logic [bqlp_pkg::CoefW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [bqlp_pkg::CoefW-1:0] en_word, b0, b1, b2,
                                 a1, a2);
        wait_drained();
        repeat (LATENCY + 2) @(posedge i_clk);
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(bqlp_pkg::CFG_B0, b0);
        write_reg(bqlp_pkg::CFG_B1, b1);
        write_reg(bqlp_pkg::CFG_B2, b2);
        write_reg(bqlp_pkg::CFG_A1, a1);
        write_reg(bqlp_pkg::CFG_A2, a2);
        write_reg(bqlp_pkg::CFG_ENABLE, en_word);
        write_reg(CFG_SPARE_HI, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input t_setting kind);
        logic [bqlp_pkg::CoefW-1:0] c [5];
        logic [bqlp_pkg::CoefW-1:0] en_word;
        en_word = $urandom() | 32'd1;
        foreach (c[k]) c[k] = $urandom();
        case (kind)
            SET_LOWPASS: begin
                // ~1 kHz corner at 44.1 kHz, Q ~0.707, small jitter
                c[0] = 32'sd2471800   + $urandom_range(255);
                c[1] = 32'sd4943600   + $urandom_range(255);
                c[2] = 32'sd2471800   + $urandom_range(255);
                c[3] = -32'sd965879000 + $urandom_range(255);
                c[4] = 32'sd438895000 + $urandom_range(255);
            end
            SET_MILD: begin
                foreach (c[k]) c[k] = $urandom_range(32'h2000_0000) - 32'h1000_0000;
            end
            SET_BYPASS:  en_word = $urandom() & ~32'd1;
            SET_EDGE_HI: begin
                c[0] = COEF_MAX; c[1] = COEF_MAX; c[2] = COEF_MAX;
                c[3] = COEF_MIN; c[4] = COEF_MIN;
            end
            SET_EDGE_LO: begin
                c[0] = COEF_MIN; c[1] = COEF_MIN; c[2] = COEF_MIN;
                c[3] = COEF_MAX; c[4] = COEF_MAX;
            end
            default: ;
        endcase
        load_settings(en_word, c[0], c[1], c[2], c[3], c[4]);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(511) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        t_setting kind;
        bq_check = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= bqlp_pkg::CFG_ENABLE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: disabled, warm-up pending
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h0001, 1'b0);

        // unity b0: warm-up passes two, then filtered copies
        load_settings(32'd1, COEF_ONE, '0, '0, '0, '0);
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0000, 1'b0);

        // extreme coefficients drive the sum into both rails
        load_settings(32'd1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h1234, 1'b1);
        send_beat(16'hEDCB, 1'b0);
        send_beat(16'h0100, 1'b0);

        // enable word with only upper bits set: bypass, history still moves
        load_settings(32'hFFFF_FFFE, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_beat(16'h4000, 1'b0);
        send_beat(16'hC000, 1'b0);
        send_beat(16'h8000, 1'b0);
        load_settings(32'd1, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h0000, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            kind = t_setting'(p % 6);
            apply_setting(kind);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (p == 0) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
                send_beat(rand_sample(), (i == 0) || ($urandom_range(99) < 4));
            end
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (bq_check.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
